// ===== sv/uvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and rounding and saturation helpers of the UV sphere vertex block.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 1'b1;

    localparam logic [8:0]  SEGMENTS_RST = 9'd16;
    localparam logic [14:0] RADIUS_RST   = 15'd256;

    // binary angle: 2^24 per turn
    localparam int TURN_BITS = 24;
    localparam int QUO_W     = TURN_BITS + 1;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam int DIV_LAT = QUO_W;
    localparam int SC_LAT  = 21;
    localparam int NRM_LAT = 4;

    typedef logic signed [31:0] t_q30;

    typedef struct packed {
        logic [8:0] lat_index;
        logic [8:0] lon_index;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        vertex_number;
        logic [16:0]        below_number;
        logic               quad_starts;
        logic               was_clamped;
    } t_out_word;

    // divide by 2^sh, round to nearest, halves away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned sh);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
        logic signed [63:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// ===== sv/uvs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_in_if
// Grid point channel: valid/ready handshake with one index word.
// ----------------------------------------------------------------------------
interface uvs_in_if;
    logic              valid;
    logic              ready;
    uvs_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/uvs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_out_if
// Vertex channel: valid/ready handshake with one vertex word.
// ----------------------------------------------------------------------------
interface uvs_out_if;
    logic               valid;
    logic               ready;
    uvs_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/uvs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_div #(
    parameter int DW = 9
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [DW+uvs_pkg::QUO_W-1:0]  i_num,
    input  logic [DW-1:0]                 i_den,
    output logic [uvs_pkg::QUO_W-1:0]     o_quo
);
    localparam int QW = uvs_pkg::QUO_W;
    localparam int NW = DW + QW;

    logic [DW-1:0] r_rem [QW];
    logic [NW-1:0] r_num [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [NW-1:0] w_num_in;
        logic [QW-1:0] w_quo_in;
        logic [DW-1:0] w_den_in;
        logic [DW:0]   w_trial;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num[NW-1:QW];
            assign w_num_in = i_num;
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_num_in = r_num[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_den_in = r_den[s-1];
        end

        assign w_trial = {w_rem_in, w_num_in[QW-1-s]};
        assign w_ge    = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? DW'(w_trial - {1'b0, w_den_in}) : w_trial[DW-1:0];
                r_num[s] <= w_num_in;
                r_quo[s] <= {w_quo_in[QW-2:0], w_ge};
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// ===== sv/uvs_hrn.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_hrn
// One Horner step t' = 1 - floor(floor(x2*t)/K) in Q30, three stages.
// ----------------------------------------------------------------------------
module uvs_hrn #(
    parameter int unsigned K  = 2,
    parameter int          SW = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_x2,
    input  logic [30:0]   i_t,
    input  logic [SW-1:0] i_side,
    output logic [31:0]   o_x2,
    output logic [30:0]   o_t,
    output logic [SW-1:0] o_side
);
    localparam logic [7:0]  KC    = 8'(K);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

    logic [61:0]   w_pa;
    logic [31:0]   r_p;
    logic [31:0]   r_x2_a;
    logic [SW-1:0] r_side_a;

    logic [63:0]   w_pb;
    logic [31:0]   r_q0;
    logic [31:0]   r_pb;
    logic [31:0]   r_x2_b;
    logic [SW-1:0] r_side_b;

    logic [39:0]   w_q0k;
    logic [39:0]   w_rem;
    logic [31:0]   w_q;
    logic [30:0]   r_t;
    logic [31:0]   r_x2_c;
    logic [SW-1:0] r_side_c;

    assign w_pa = 62'(i_x2) * 62'(i_t);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= w_pa[61:30];
            r_x2_a   <= i_x2;
            r_side_a <= i_side;
        end
    end

    // reciprocal estimate, at most one low
    assign w_pb = 64'(r_p) * 64'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0     <= w_pb[63:32];
            r_pb     <= r_p;
            r_x2_b   <= r_x2_a;
            r_side_b <= r_side_a;
        end
    end

    assign w_q0k = 40'(r_q0) * 40'(KC);
    assign w_rem = 40'(r_pb) - w_q0k;
    assign w_q   = r_q0 + ((w_rem >= 40'(KC)) ? 32'd1 : 32'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= (w_q >= 32'(uvs_pkg::Q30_ONE)) ? 31'd0
                                                       : 31'(32'(uvs_pkg::Q30_ONE) - w_q);
            r_x2_c   <= r_x2_b;
            r_side_c <= r_side_b;
        end
    end

    assign o_x2   = r_x2_c;
    assign o_t    = r_t;
    assign o_side = r_side_c;

endmodule

// ===== sv/uvs_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sincos
// Sine and cosine of a binary angle, Taylor series in Horner form, Q30.
// ----------------------------------------------------------------------------
module uvs_sincos (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [uvs_pkg::TURN_BITS-1:0]   i_ang,
    output uvs_pkg::t_q30                   o_sin,
    output uvs_pkg::t_q30                   o_cos
);
    localparam int RW        = uvs_pkg::TURN_BITS - 2;
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam int unsigned SIN_K [SIN_STEPS] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_K [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

    localparam logic [1:0] QD_0 = 2'd0;
    localparam logic [1:0] QD_1 = 2'd1;
    localparam logic [1:0] QD_2 = 2'd2;
    localparam logic [1:0] QD_3 = 2'd3;

    logic [52:0] w_xprod;
    logic [30:0] r_x;
    logic [1:0]  r_q1;

    logic [61:0] w_x2prod;
    logic [31:0] r_x2;
    logic [30:0] r_x_s2;
    logic [1:0]  r_q2;

    logic [31:0] w_cx2 [COS_STEPS+1];
    logic [30:0] w_ct  [COS_STEPS+1];
    logic [1:0]  w_cq  [COS_STEPS+1];

    logic [31:0] w_sx2 [SIN_STEPS+1];
    logic [30:0] w_st  [SIN_STEPS+1];
    logic [30:0] w_sx  [SIN_STEPS+1];

    logic [61:0] w_sprod;
    logic [30:0] w_s;
    logic [30:0] r_s0;
    logic [30:0] r_s1;
    logic [30:0] r_s2;

    uvs_pkg::t_q30 w_sv;
    uvs_pkg::t_q30 w_cv;
    uvs_pkg::t_q30 r_sin;
    uvs_pkg::t_q30 r_cos;

    // quadrant remainder to radians
    assign w_xprod = 53'(i_ang[RW-1:0]) * 53'(uvs_pkg::HALF_PI_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= w_xprod[52:22];
            r_q1 <= i_ang[uvs_pkg::TURN_BITS-1:RW];
        end
    end

    assign w_x2prod = 62'(r_x) * 62'(r_x);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2   <= w_x2prod[61:30];
            r_x_s2 <= r_x;
            r_q2   <= r_q1;
        end
    end

    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = uvs_pkg::Q30_ONE;
    assign w_cq[0]  = r_q2;

    for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
        uvs_hrn #(.K(COS_K[i]), .SW(2)) u_hrn (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x2   (w_cx2[i]),
            .i_t    (w_ct[i]),
            .i_side (w_cq[i]),
            .o_x2   (w_cx2[i+1]),
            .o_t    (w_ct[i+1]),
            .o_side (w_cq[i+1])
        );
    end

    assign w_sx2[0] = r_x2;
    assign w_st[0]  = uvs_pkg::Q30_ONE;
    assign w_sx[0]  = r_x_s2;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
        uvs_hrn #(.K(SIN_K[i]), .SW(31)) u_hrn (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x2   (w_sx2[i]),
            .i_t    (w_st[i]),
            .i_side (w_sx[i]),
            .o_x2   (w_sx2[i+1]),
            .o_t    (w_st[i+1]),
            .o_side (w_sx[i+1])
        );
    end

    assign w_sprod = 62'(w_st[SIN_STEPS]) * 62'(w_sx[SIN_STEPS]);
    assign w_s     = w_sprod[60:30];

    // sine chain is one step shorter: pad to the cosine depth
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= (w_s > uvs_pkg::Q30_ONE) ? uvs_pkg::Q30_ONE : w_s;
            r_s1 <= r_s0;
            r_s2 <= r_s1;
        end
    end

    assign w_sv = $signed({1'b0, r_s2});
    assign w_cv = $signed({1'b0, w_ct[COS_STEPS]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (w_cq[COS_STEPS])
                QD_0: begin
                    r_sin <= w_sv;
                    r_cos <= w_cv;
                end
                QD_1: begin
                    r_sin <= w_cv;
                    r_cos <= -w_sv;
                end
                QD_2: begin
                    r_sin <= -w_sv;
                    r_cos <= -w_cv;
                end
                QD_3: begin
                    r_sin <= -w_cv;
                    r_cos <= w_sv;
                end
            endcase
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== sv/uvs_nrm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_nrm
// Normal from the trig terms, scaling by radius, rounding and saturation.
// ----------------------------------------------------------------------------
module uvs_nrm (
    input  logic               i_clk,
    input  logic               i_en,
    input  uvs_pkg::t_q30      i_st,
    input  uvs_pkg::t_q30      i_ct,
    input  uvs_pkg::t_q30      i_sp,
    input  uvs_pkg::t_q30      i_cp,
    input  logic [14:0]        i_radius,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z
);
    logic signed [63:0] r_mx;
    logic signed [63:0] r_mz;
    uvs_pkg::t_q30      r_ny;

    uvs_pkg::t_q30      r_n  [3];
    logic signed [47:0] r_pr [3];
    logic signed [15:0] r_nm [3];
    logic signed [15:0] r_pos [3];
    logic signed [15:0] r_nm_d [3];
    logic signed [15:0] w_rad;

    assign w_rad = $signed({1'b0, i_radius});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx <= 64'(i_cp) * 64'(i_st);
            r_mz <= 64'(i_sp) * 64'(i_st);
            r_ny <= i_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= 32'(uvs_pkg::round_shift(r_mx, 30));
            r_n[1] <= r_ny;
            r_n[2] <= 32'(uvs_pkg::round_shift(r_mz, 30));
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pr[i]   <= 48'(r_n[i]) * 48'(w_rad);
                r_nm[i]   <= 16'(uvs_pkg::sat(uvs_pkg::round_shift(64'(r_n[i]), 16),
                                              -64'sd16384, 64'sd16384));
                r_pos[i]  <= 16'(uvs_pkg::sat(uvs_pkg::round_shift(64'(r_pr[i]), 30),
                                              -64'sd32768, 64'sd32767));
                r_nm_d[i] <= r_nm[i];
            end
        end
    end

    assign o_pos_x  = r_pos[0];
    assign o_pos_y  = r_pos[1];
    assign o_pos_z  = r_pos[2];
    assign o_norm_x = r_nm_d[0];
    assign o_norm_y = r_nm_d[1];
    assign o_norm_z = r_nm_d[2];

endmodule

// ===== sv/uv_sphere_vertex_generator_top.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top
// Path from input word to output word: input register, 25-stage divider,
// 21-stage sine/cosine, 4-stage normal/position path.
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// Reset: synchronous, clears the pipeline valid bits, segments to 16, radius to 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_top #(
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    uvs_in_if.sink                           i_in,
    uvs_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int IW       = $clog2(MAX_SEGMENTS + 1);
    localparam int NW       = IW + uvs_pkg::QUO_W;
    localparam int PIPE_LAT = uvs_pkg::DIV_LAT + uvs_pkg::SC_LAT + uvs_pkg::NRM_LAT;
    localparam int VLD_N    = PIPE_LAT + 1;

    typedef struct packed {
        logic [16:0] vertex_number;
        logic [16:0] below_number;
        logic        quad_starts;
        logic        was_clamped;
    } t_side;

    logic [8:0]  r_segments;
    logic [14:0] r_radius;

    logic        w_en;
    logic [VLD_N-1:0] r_vld;

    logic [31:0] w_seg32;
    logic [31:0] w_lat32;
    logic [31:0] w_lon32;
    logic        w_clamp;

    logic [IW-1:0] r_lat;
    logic [IW-1:0] r_lon;
    logic [IW-1:0] r_seg;
    logic          r_clamp;

    logic [NW-1:0] w_num_t;
    logic [NW-1:0] w_num_p;
    logic [uvs_pkg::QUO_W-1:0] w_quo_t;
    logic [uvs_pkg::QUO_W-1:0] w_quo_p;

    logic [31:0] w_vnum;
    logic [31:0] w_bnum;
    t_side       w_side;
    t_side       r_side [PIPE_LAT];

    uvs_pkg::t_q30 w_st;
    uvs_pkg::t_q30 w_ct;
    uvs_pkg::t_q30 w_sp;
    uvs_pkg::t_q30 w_cp;

    logic signed [15:0] w_pos_x;
    logic signed [15:0] w_pos_y;
    logic signed [15:0] w_pos_z;
    logic signed [15:0] w_norm_x;
    logic signed [15:0] w_norm_y;
    logic signed [15:0] w_norm_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segments <= uvs_pkg::SEGMENTS_RST;
            r_radius   <= uvs_pkg::RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uvs_pkg::CFG_SEGMENTS: r_segments <= i_cfg_data[8:0];
                uvs_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data;
            endcase
        end
    end

    assign w_en       = !r_vld[VLD_N-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_seg32 = 32'(r_segments);
        if (w_seg32 == 32'd0) begin
            w_seg32 = 32'd1;
        end else if (w_seg32 > 32'(MAX_SEGMENTS)) begin
            w_seg32 = 32'(MAX_SEGMENTS);
        end
        w_lat32 = 32'(i_in.data.lat_index);
        w_lon32 = 32'(i_in.data.lon_index);
        w_clamp = 1'b0;
        if (w_lat32 > w_seg32) begin
            w_lat32 = w_seg32;
            w_clamp = 1'b1;
        end
        if (w_lon32 > w_seg32) begin
            w_lon32 = w_seg32;
            w_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLD_N-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat   <= w_lat32[IW-1:0];
            r_lon   <= w_lon32[IW-1:0];
            r_seg   <= w_seg32[IW-1:0];
            r_clamp <= w_clamp;
        end
    end

    // theta spans a half turn, phi a full turn; seg/2 rounds to nearest
    assign w_num_t = (NW'(r_lat) << (uvs_pkg::TURN_BITS - 1)) + NW'(r_seg >> 1);
    assign w_num_p = (NW'(r_lon) << uvs_pkg::TURN_BITS) + NW'(r_seg >> 1);

    uvs_div #(.DW(IW)) u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_t),
        .i_den (r_seg),
        .o_quo (w_quo_t)
    );

    uvs_div #(.DW(IW)) u_div_p (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num_p),
        .i_den (r_seg),
        .o_quo (w_quo_p)
    );

    uvs_sincos u_sc_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (w_quo_t[uvs_pkg::TURN_BITS-1:0]),
        .o_sin (w_st),
        .o_cos (w_ct)
    );

    uvs_sincos u_sc_p (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ang (w_quo_p[uvs_pkg::TURN_BITS-1:0]),
        .o_sin (w_sp),
        .o_cos (w_cp)
    );

    uvs_nrm u_nrm (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_st     (w_st),
        .i_ct     (w_ct),
        .i_sp     (w_sp),
        .i_cp     (w_cp),
        .i_radius (r_radius),
        .o_pos_x  (w_pos_x),
        .o_pos_y  (w_pos_y),
        .o_pos_z  (w_pos_z),
        .o_norm_x (w_norm_x),
        .o_norm_y (w_norm_y),
        .o_norm_z (w_norm_z)
    );

    assign w_vnum = 32'(r_lat) * (32'(r_seg) + 32'd1) + 32'(r_lon);
    assign w_bnum = w_vnum + 32'(r_seg) + 32'd1;

    assign w_side.vertex_number = w_vnum[16:0];
    assign w_side.below_number  = w_bnum[16:0];
    assign w_side.quad_starts   = (r_lat < r_seg) && (r_lon < r_seg);
    assign w_side.was_clamped   = r_clamp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_out.valid              = r_vld[VLD_N-1];
    assign o_out.data.pos_x         = w_pos_x;
    assign o_out.data.pos_y         = w_pos_y;
    assign o_out.data.pos_z         = w_pos_z;
    assign o_out.data.norm_x        = w_norm_x;
    assign o_out.data.norm_y        = w_norm_y;
    assign o_out.data.norm_z        = w_norm_z;
    assign o_out.data.vertex_number = r_side[PIPE_LAT-1].vertex_number;
    assign o_out.data.below_number  = r_side[PIPE_LAT-1].below_number;
    assign o_out.data.quad_starts   = r_side[PIPE_LAT-1].quad_starts;
    assign o_out.data.was_clamped   = r_side[PIPE_LAT-1].was_clamped;

endmodule

// ===== sv/uvs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_chk
// Port-level checks of the UV sphere vertex block, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input uvs_pkg::t_out_word i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output word changed while stalled");

    a_quad_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.quad_starts && i_out_data.was_clamped))
        else $error("quad flagged on a saturated index");

    a_ring_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 17'(i_out_data.below_number - i_out_data.vertex_number) >= 17'd2)
        else $error("below index not one ring further");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

endmodule

bind uv_sphere_vertex_generator_top uvs_chk u_uvs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== sim/tb_uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator_top
// Streams grid points through the UV sphere vertex block at several segment
// counts and radii, predicts each vertex word in fixed point and compares it
// field by field under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator_top;

    localparam int CLK_HALF   = 10;
    localparam int LATENCY    = 51;
    localparam int CYCLE_CAP  = 400000;
    localparam int N_RANDOM   = 1850;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [uvs_pkg::CFG_IDX_W-1:0] i_cfg_idx = uvs_pkg::CFG_SEGMENTS;
    logic [uvs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    uvs_in_if  in_ch ();
    uvs_out_if out_ch ();

    uv_sphere_vertex_generator_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch.sink),
        .o_out     (out_ch.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    int errors = 0;
    int cycles = 0;
    bit sink_idle_on = 1'b1;
    bit sink_hold = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    class vertex_scoreboard;
        logic [8:0]  seg_reg;
        logic [14:0] rad_reg;
        uvs_pkg::t_out_word pending[$];

        function new();
            seg_reg = uvs_pkg::SEGMENTS_RST;
            rad_reg = uvs_pkg::RADIUS_RST;
        endfunction

        function automatic longint unsigned series(longint unsigned x2, bit is_cos);
            longint unsigned t, sub;
            int k[6];
            int n;
            if (is_cos) begin
                k = '{132, 90, 56, 30, 12, 2};
                n = 6;
            end else begin
                k = '{110, 72, 42, 20, 6, 0};
                n = 5;
            end
            t = 64'd1 << 30;
            for (int i = 0; i < n; i++) begin
                sub = ((x2 * t) >> 30) / 64'(k[i]);
                t = (sub >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - sub;
            end
            return t;
        endfunction

        function automatic void trig(input logic [23:0] a, output longint sv,
                                     output longint cv);
            longint unsigned r, x, x2, s, c;
            r = 64'(a[21:0]);
            x = (r * 64'd1686629713) >> 22;
            x2 = (x * x) >> 30;
            s = (x * series(x2, 1'b0)) >> 30;
            c = series(x2, 1'b1);
            if (s > (64'd1 << 30)) s = 64'd1 << 30;
            if (c > (64'd1 << 30)) c = 64'd1 << 30;
            case (a[23:22])
                2'd0: begin sv = s;  cv = c;  end
                2'd1: begin sv = c;  cv = -longint'(s); end
                2'd2: begin sv = -longint'(s); cv = -longint'(c); end
                default: begin sv = -longint'(c); cv = s; end
            endcase
        endfunction

        function automatic longint rnd(longint v, int sh);
            longint unsigned m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function automatic longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] idx, logic [14:0] val);
            if (idx == uvs_pkg::CFG_SEGMENTS) seg_reg = val[8:0];
            else if (idx == uvs_pkg::CFG_RADIUS) rad_reg = val;
        endfunction

        function void note_input(uvs_pkg::t_in_word w);
            longint unsigned seg, lat, lon, vn;
            longint st, ct, sp, cp;
            longint rad;
            longint n[3];
            logic [23:0] ta, pa;
            uvs_pkg::t_out_word e;
            seg = 64'(seg_reg);
            rad = longint'(64'(rad_reg));
            if (seg < 1) seg = 1;
            if (seg > 256) seg = 256;
            lat = 64'(w.lat_index);
            lon = 64'(w.lon_index);
            e.was_clamped = 1'b0;
            if (lat > seg) begin lat = seg; e.was_clamped = 1'b1; end
            if (lon > seg) begin lon = seg; e.was_clamped = 1'b1; end
            ta = 24'(((lat << 23) + seg / 2) / seg);
            pa = 24'(((lon << 24) + seg / 2) / seg);
            trig(ta, st, ct);
            trig(pa, sp, cp);
            n[0] = rnd(cp * st, 30);
            n[1] = ct;
            n[2] = rnd(sp * st, 30);
            e.pos_x = 16'(clip(rnd(n[0] * rad, 30), -32768, 32767));
            e.pos_y = 16'(clip(rnd(n[1] * rad, 30), -32768, 32767));
            e.pos_z = 16'(clip(rnd(n[2] * rad, 30), -32768, 32767));
            e.norm_x = 16'(clip(rnd(n[0], 16), -16384, 16384));
            e.norm_y = 16'(clip(rnd(n[1], 16), -16384, 16384));
            e.norm_z = 16'(clip(rnd(n[2], 16), -16384, 16384));
            vn = lat * (seg + 1) + lon;
            e.vertex_number = 17'(vn);
            e.below_number = 17'(vn + seg + 1);
            e.quad_starts = (lat < seg) && (lon < seg);
            pending.insert(pending.size(), e);
        endfunction

        task check_output(uvs_pkg::t_out_word g);
            uvs_pkg::t_out_word e;
            if (pending.size() == 0) begin
                report("unexpected word vertex_number", g.vertex_number, -1);
                return;
            end
            e = pending.pop_front();
            if (g.pos_x !== e.pos_x) report("pos_x", g.pos_x, e.pos_x);
            if (g.pos_y !== e.pos_y) report("pos_y", g.pos_y, e.pos_y);
            if (g.pos_z !== e.pos_z) report("pos_z", g.pos_z, e.pos_z);
            if (g.norm_x !== e.norm_x) report("norm_x", g.norm_x, e.norm_x);
            if (g.norm_y !== e.norm_y) report("norm_y", g.norm_y, e.norm_y);
            if (g.norm_z !== e.norm_z) report("norm_z", g.norm_z, e.norm_z);
            if (g.vertex_number !== e.vertex_number)
                report("vertex_number", g.vertex_number, e.vertex_number);
            if (g.below_number !== e.below_number)
                report("below_number", g.below_number, e.below_number);
            if (g.quad_starts !== e.quad_starts)
                report("quad_starts", g.quad_starts, e.quad_starts);
            if (g.was_clamped !== e.was_clamped)
                report("was_clamped", g.was_clamped, e.was_clamped);
        endtask
    endclass

    vertex_scoreboard vertices = new();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) vertices.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready) vertices.check_output(out_ch.data);
        end
        if (cycles > CYCLE_CAP) begin
            $display("tb_uv_sphere_vertex_generator_top failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || sink_hold) out_ch.ready <= 1'b0;
        else out_ch.ready <= !sink_idle_on || ($urandom_range(99) >= 33);
    end

    task automatic send_point(input logic [8:0] lat, input logic [8:0] lon,
                              input bit idle);
        while (idle && $urandom_range(99) < 33) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= '{lat_index: lat, lon_index: lon};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (vertices.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [uvs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [14:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        vertices.write_reg(idx, val);
    endtask

    task automatic random_points(input int n, input bit idle);
        logic [8:0] s;
        for (int i = 0; i < n; i++) begin
            s = vertices.seg_reg;
            if ($urandom_range(9) == 0)
                send_point(9'($urandom_range(511)), 9'($urandom_range(511)), idle);
            else
                send_point(9'($urandom_range(32'(s))), 9'($urandom_range(32'(s))), idle);
        end
    endtask

    initial begin
        logic [8:0]  segs[7];
        logic [14:0] rads[7];
        segs = '{16, 1, 256, 0, 3, 511, 7};
        rads = '{256, 0, 32767, 1, 4096, 12345, 256};
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: poles, seams, extremes, clamping at reset settings
        send_point(0, 0, 1'b0);
        send_point(16, 16, 1'b0);
        send_point(8, 4, 1'b0);
        send_point(8, 12, 1'b0);
        send_point(15, 15, 1'b0);
        send_point(17, 0, 1'b0);
        send_point(0, 511, 1'b0);
        send_point(511, 511, 1'b0);
        send_point(8, 8, 1'b0);
        send_point(4, 0, 1'b0);
        drain();
        write_reg(uvs_pkg::CFG_SEGMENTS, 256);
        write_reg(uvs_pkg::CFG_RADIUS, 32767);
        send_point(256, 256, 1'b0);
        send_point(128, 64, 1'b0);
        send_point(255, 255, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(257, 170, 1'b0);
        send_point(85, 341, 1'b0);
        drain();
        write_reg(uvs_pkg::CFG_SEGMENTS, 0);
        send_point(0, 1, 1'b0);
        send_point(1, 0, 1'b0);
        send_point(2, 2, 1'b0);
        drain();

        for (int p = 0; p < 7; p++) begin
            write_reg(uvs_pkg::CFG_SEGMENTS, 15'(segs[p]));
            write_reg(uvs_pkg::CFG_RADIUS, rads[p]);
            sink_idle_on = (p != 2);
            random_points(N_RANDOM / 7, p != 2);
            if (p == 4) begin
                // sender holds until the pipeline is empty, sink fully stalled first
                in_ch.valid <= 1'b0;
                sink_hold = 1'b1;
                repeat (80) @(negedge i_clk);
                sink_hold = 1'b0;
                while (vertices.pending.size() != 0) @(negedge i_clk);
                random_points(20, 1'b1);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_uv_sphere_vertex_generator_top passed");
        end else begin
            $display("tb_uv_sphere_vertex_generator_top failed");
        end
        $finish;
    end
endmodule

// ===== uv_sphere_vertex_generator_top.f =====
sv/uvs_pkg.sv
sv/uvs_in_if.sv
sv/uvs_out_if.sv
sv/uvs_div.sv
sv/uvs_hrn.sv
sv/uvs_sincos.sv
sv/uvs_nrm.sv
sv/uv_sphere_vertex_generator_top.sv
sv/uvs_chk.sv
sim/tb_uv_sphere_vertex_generator_top.sv
